// ----- design/hcbp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_pkg: shared types and constants
// Code table entry, packed output byte record and opcode names for the
// Huffman code bit packer.
// ---------------------------------------------------------------------------
package hcbp_pkg;

  localparam int BYTE_W     = 8;
  localparam int SYM_W      = 8;
  localparam int LEN_W      = 6;
  localparam int CODE_W     = 32;
  localparam int PAD_W      = 3;
  localparam int TBL_DEPTH  = 256;
  // most bytes one item can produce
  localparam int MAX_BURST  = 4;
  localparam int BURST_W    = 3;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] value;
  } tbl_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [PAD_W-1:0]  pad_bits;
    logic              last;
  } out_item_t;

  localparam int TBL_ENTRY_W = $bits(tbl_entry_t);

endpackage

// ----- design/hcbp_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/hcbp_out_fifo.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbp_out_fifo: output byte queue
// Takes a burst of up to four bytes per cycle, hands out one byte per
// transfer on the output channel.
// ---------------------------------------------------------------------------
module hcbp_out_fifo #(
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [hcbp_pkg::BURST_W-1:0]          push_n,
  input  hcbp_pkg::out_item_t [hcbp_pkg::MAX_BURST-1:0] push_items,
  output hcbp_pkg::out_item_t                   head,
  output logic                                  head_valid,
  input  logic                                  pop,
  output logic [$clog2(DEPTH):0]                count
);
  import hcbp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  out_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [PTR_W:0]     count_next;
  logic               do_pop;

  assign head       = slots[rptr];
  assign head_valid = (count != '0);
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_next = count + {{(PTR_W+1-BURST_W){1'b0}}, push_n} - {{PTR_W{1'b0}}, do_pop};
  end

  // burst write at consecutive slots
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_BURST; k++) begin
      if (k < int'(push_n)) begin
        slots[wptr + PTR_W'(k)] <= push_items[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push_n);
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // occupancy stays within the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count + {{(PTR_W+1-BURST_W){1'b0}}, push_n}) <= (PTR_W+1)'(DEPTH))
    else $error("output queue overflow");

  // count tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count_next))
    else $error("output queue count mismatch");

  // a burst never exceeds four bytes
  a_burst_size: assert property (@(posedge clk) disable iff (rst)
    push_n <= BURST_W'(MAX_BURST))
    else $error("burst too long");

endmodule

// ----- design/huffman_code_bit_packer_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// huffman_code_bit_packer_top: Huffman code table and MSB-first bit packer
// Load items fill a 256-entry code table, encode items append a symbol's
// code to the packer and emit completed bytes, flush items pad and emit
// the final partial byte.
// ---------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  input   | in_valid / in_stall | opcode, symbol, code_length, code_value
//  output  | out_valid/out_stall | out_byte, pad_bits, last
//
//  One input item per cycle unless in_stall is high. An encode item reads
//  the table in the accept cycle and packs in the next one; its bytes enter
//  a 16-entry output queue. The output channel moves one byte per cycle
//  unless out_stall is high; the input stalls while the queue has fewer
//  than four free slots beyond the packing stage's burst.
//  Reset clears the table valid bits and the packer at once: no sweep.
// ---------------------------------------------------------------------------
module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [hcbp_pkg::SYM_W-1:0]    symbol,
  input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
  input  logic [hcbp_pkg::CODE_W-1:0]   code_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  output logic [hcbp_pkg::PAD_W-1:0]    pad_bits,
  output logic                          last
);
  import hcbp_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam int CNT_W      = $clog2(FIFO_DEPTH) + 1;
  localparam int LEN_CAP_I  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);
  localparam int ACC_W      = CODE_W + BYTE_W - 1;  // 39
  localparam int WIN_W      = ACC_W + 1;            // 40

  logic              in_xfer;
  logic              is_load;
  logic              is_enc;
  logic              is_flush;
  logic [LEN_W-1:0]  len_sat;
  tbl_entry_t        wr_entry;
  tbl_entry_t        rd_entry;
  logic [TBL_DEPTH-1:0] tbl_valid;

  logic              s1_valid;
  logic              s1_flush;
  logic              s1_hit;

  logic [BYTE_W-2:0] pend_bits;
  logic [PAD_W-1:0]  pend_cnt;
  logic [BYTE_W-2:0] pend_bits_next;
  logic [PAD_W-1:0]  pend_cnt_next;

  logic [LEN_W-1:0]  enc_len;
  logic [CODE_W:0]   len_mask_n;
  logic [CODE_W-1:0] code_m;
  logic [ACC_W-1:0]  acc;
  logic [LEN_W-1:0]  total;
  logic [WIN_W-1:0]  win;
  logic [PAD_W-1:0]  rem;
  logic [PAD_W-1:0]  pad;

  logic [BURST_W-1:0]               push_n;
  out_item_t [MAX_BURST-1:0]        push_items;
  out_item_t                        head;
  logic [CNT_W-1:0]                 fifo_cnt;

  // input decode
  assign in_xfer  = in_valid && !in_stall;
  assign is_load  = in_xfer && (opcode == OP_LOAD);
  assign is_enc   = in_xfer && (opcode == OP_ENCODE);
  assign is_flush = in_xfer && (opcode == OP_FLUSH);
  assign len_sat  = (code_length > LEN_CAP) ? LEN_CAP : code_length;
  assign wr_entry = '{len: len_sat, value: code_value};

  // reserve a full burst for the packing stage
  assign in_stall = (fifo_cnt + (s1_valid ? CNT_W'(MAX_BURST) : '0))
                    > CNT_W'(FIFO_DEPTH - MAX_BURST);

  hcbp_ram #(
    .WIDTH (TBL_ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (is_load),
    .wr_addr (symbol),
    .wr_data (wr_entry),
    .rd_en   (is_enc),
    .rd_addr (symbol),
    .rd_data (rd_entry)
  );

  // valid bits and stage-1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_valid <= '0;
      s1_valid  <= 1'b0;
      s1_flush  <= 1'b0;
      s1_hit    <= 1'b0;
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else begin
      if (is_load) begin
        tbl_valid[symbol] <= 1'b1;
      end
      s1_valid  <= is_enc || is_flush;
      s1_flush  <= is_flush;
      s1_hit    <= tbl_valid[symbol];
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  // packing: append code behind pending bits, left-align into a window
  always_comb begin
    enc_len    = s1_hit ? rd_entry.len : '0;
    len_mask_n = {(CODE_W+1){1'b1}} << enc_len;
    code_m     = rd_entry.value & ~len_mask_n[CODE_W-1:0];
    acc        = ({{(ACC_W-BYTE_W+1){1'b0}}, pend_bits} << enc_len)
                 | {{(ACC_W-CODE_W){1'b0}}, code_m};
    total      = {{(LEN_W-PAD_W){1'b0}}, pend_cnt} + enc_len;
    win        = {1'b0, acc} << (LEN_W'(WIN_W) - total);
    rem        = total[PAD_W-1:0];
    pad        = PAD_W'(BYTE_W - int'(pend_cnt));

    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    push_n         = '0;
    for (int k = 0; k < MAX_BURST; k++) begin
      push_items[k].out_byte = win[WIN_W-1-BYTE_W*k -: BYTE_W];
      push_items[k].pad_bits = '0;
      push_items[k].last     = (k == int'(total[LEN_W-1:PAD_W]) - 1);
    end

    if (s1_valid) begin
      if (s1_flush) begin
        if (pend_cnt != '0) begin
          push_items[0].out_byte = BYTE_W'({1'b0, pend_bits} << pad);
          push_items[0].pad_bits = pad;
          push_items[0].last     = 1'b1;
          push_n                 = BURST_W'(1);
        end
        pend_bits_next = '0;
        pend_cnt_next  = '0;
      end else begin
        push_n         = total[LEN_W-1:PAD_W];
        pend_bits_next = acc[BYTE_W-2:0] & ~({(BYTE_W-1){1'b1}} << rem);
        pend_cnt_next  = rem;
      end
    end
  end

  hcbp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_ofifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push_items (push_items),
    .head       (head),
    .head_valid (out_valid),
    .pop        (!out_stall),
    .count      (fifo_cnt)
  );

  assign out_byte = head.out_byte;
  assign pad_bits = head.pad_bits;
  assign last     = head.last;

  // a loaded entry is marked valid on the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    is_load |=> tbl_valid[$past(symbol)])
    else $error("table entry not marked valid after load");

  // a flush always empties the packer
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_flush) |=> (pend_cnt == '0) && (pend_bits == '0))
    else $error("packer not empty after flush");

  // pending bits above the pending count stay zero
  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (pend_bits & ({(BYTE_W-1){1'b1}} << pend_cnt)) == '0)
    else $error("stray pending bits");

endmodule
